FILE: rtl/spq_pkg.sv
package spq_pkg;

  // queue geometry
  localparam int unsigned DEPTH        = 16;
  localparam int unsigned PAYLOAD_BITS = 32;
  localparam int unsigned PRI_W        = 8;
  localparam int unsigned CNT_W        = $clog2(DEPTH + 1);

  // operation codes carried by the action field
  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_POP    = 1'b1;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic ins;  // insert the new word at its sorted place
    logic pop;  // shift everything one slot towards the head
  } spq_ctrl_t;

endpackage

FILE: rtl/spq_cell.sv
module spq_cell (
  input  logic                                  clk_i,
  input  spq_pkg::spq_ctrl_t                    ctrl_i,
  input  logic                                  occ_i,
  input  logic [spq_pkg::PRI_W-1:0]             new_pri_i,
  input  logic [spq_pkg::PAYLOAD_BITS-1:0]      new_pay_i,
  input  logic                                  keep_left_i,
  input  logic [spq_pkg::PRI_W-1:0]             left_pri_i,
  input  logic [spq_pkg::PAYLOAD_BITS-1:0]      left_pay_i,
  input  logic [spq_pkg::PRI_W-1:0]             right_pri_i,
  input  logic [spq_pkg::PAYLOAD_BITS-1:0]      right_pay_i,
  output logic                                  keep_o,
  output logic [spq_pkg::PRI_W-1:0]             pri_o,
  output logic [spq_pkg::PAYLOAD_BITS-1:0]      pay_o
);
  import spq_pkg::*;

  logic [PRI_W-1:0]        pri_q, pri_d;
  logic [PAYLOAD_BITS-1:0] pay_q, pay_d;

  // an occupied entry of greater or equal priority stays ahead of the new word
  assign keep_o = occ_i && (pri_q >= new_pri_i);

  // next slot contents: hold, take the new word, or shift from a neighbour
  always_comb begin
    pri_d = pri_q;
    pay_d = pay_q;
    if (ctrl_i.ins) begin
      if (!keep_o) begin
        if (keep_left_i) begin
          pri_d = new_pri_i;
          pay_d = new_pay_i;
        end else begin
          pri_d = left_pri_i;
          pay_d = left_pay_i;
        end
      end
    end else if (ctrl_i.pop) begin
      pri_d = right_pri_i;
      pay_d = right_pay_i;
    end
  end

  // slot storage, no reset needed: occupancy comes from the count
  always_ff @(posedge clk_i) begin
    pri_q <= pri_d;
    pay_q <= pay_d;
  end

  assign pri_o = pri_q;
  assign pay_o = pay_q;

endmodule

FILE: rtl/stable_priority_queue_core.sv
// Sorted priority queue built as a row of shift cells, head in cell 0.
// Result word is registered, valid in the cycle after its input is accepted.
// Throughput: one insert or pop per cycle unless a held result stalls; each
// cell compares with the new priority in parallel and shifts in the same cycle.
// Reset: count and output valid cleared asynchronously; slot data is not reset.
module stable_priority_queue_core (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic                                  action_i,
  input  logic [spq_pkg::PRI_W-1:0]             priority_req_i,
  input  logic [spq_pkg::PAYLOAD_BITS-1:0]      payload_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic                                  ok_o,
  output logic [spq_pkg::PRI_W-1:0]             out_priority_o,
  output logic [spq_pkg::PAYLOAD_BITS-1:0]      out_payload_o,
  output logic [spq_pkg::CNT_W-1:0]             entry_count_o
);
  import spq_pkg::*;

  logic                    accept;
  logic                    full, empty;
  logic                    do_ins, do_pop;
  spq_ctrl_t               ctrl;
  logic [CNT_W-1:0]        count_q, count_d;
  logic                    out_valid_q;
  logic                    ok_q;
  logic [PRI_W-1:0]        opri_q;
  logic [PAYLOAD_BITS-1:0] opay_q;
  logic [CNT_W-1:0]        ocnt_q;

  logic                    keep_w [DEPTH];
  logic [PRI_W-1:0]        pri_w  [DEPTH];
  logic [PAYLOAD_BITS-1:0] pay_w  [DEPTH];

  // output register frees as soon as its word is taken
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  assign full   = (count_q == CNT_W'(DEPTH));
  assign empty  = (count_q == '0);
  assign do_ins = accept && (action_i == ACT_INSERT) && !full;
  assign do_pop = accept && (action_i == ACT_POP) && !empty;

  assign ctrl.ins = do_ins;
  assign ctrl.pop = do_pop;

  // entry count
  always_comb begin
    count_d = count_q;
    if (do_ins) begin
      count_d = count_q + CNT_W'(1);
    end else if (do_pop) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  // row of cells, each wired to its neighbours
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                    keep_left;
    logic [PRI_W-1:0]        left_pri, right_pri;
    logic [PAYLOAD_BITS-1:0] left_pay, right_pay;

    if (i == 0) begin : g_head
      assign keep_left = 1'b1;
      assign left_pri  = '0;
      assign left_pay  = '0;
    end else begin : g_mid
      assign keep_left = keep_w[i-1];
      assign left_pri  = pri_w[i-1];
      assign left_pay  = pay_w[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_pri = '0;
      assign right_pay = '0;
    end else begin : g_body
      assign right_pri = pri_w[i+1];
      assign right_pay = pay_w[i+1];
    end

    spq_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .occ_i       (CNT_W'(i) < count_q),
      .new_pri_i   (priority_req_i),
      .new_pay_i   (payload_i),
      .keep_left_i (keep_left),
      .left_pri_i  (left_pri),
      .left_pay_i  (left_pay),
      .right_pri_i (right_pri),
      .right_pay_i (right_pay),
      .keep_o      (keep_w[i]),
      .pri_o       (pri_w[i]),
      .pay_o       (pay_w[i])
    );
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result word
  always_ff @(posedge clk_i) begin
    if (accept) begin
      ok_q   <= do_ins || do_pop;
      opri_q <= do_pop ? pri_w[0] : '0;
      opay_q <= do_pop ? pay_w[0] : '0;
      ocnt_q <= count_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign ok_o           = ok_q;
  assign out_priority_o = opri_q;
  assign out_payload_o  = opay_q;
  assign entry_count_o  = ocnt_q;

endmodule
